[rtl/core/wsfu_pkg.sv]
// ----------------------------------------------------------------------------
// WebSocket frame unmasker package
// Shared types and constants for the header parser, the word queue and the
// unmasking back end.
// ----------------------------------------------------------------------------
package wsfu_pkg;

  localparam logic [7:0] FirstDefault = 8'h82;
  localparam logic [6:0] LenExt16     = 7'd126;
  localparam logic [6:0] LenExt64     = 7'd127;
  localparam logic [2:0] ExtCount16   = 3'd1;
  localparam logic [2:0] ExtCount64   = 3'd7;
  localparam logic [2:0] KeyCount     = 3'd3;
  localparam int unsigned FifoDepth   = 4;

  typedef enum logic [2:0] {
    PhFirst   = 3'd0,
    PhLen     = 3'd1,
    PhExt     = 3'd2,
    PhKey     = 3'd3,
    PhPayload = 3'd4
  } phase_e;

  // One payload word on its way from the parser to the back end.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
    logic       masked;
    logic       mismatch;
  } wsfu_entry_t;

endpackage

[rtl/core/websocket_frame_unmasker.sv]
// A payload word accepted by the parser is written into the queue, then
// moves into the output register once that is empty or popped; header words
// give no result. One word is taken per cycle while full is low; full rises
// only when the queue between parser and output register is full because
// results are not popped. Reset clears the parser state, empties the queue
// and the output register, and sets the expected first header word to 0x82.
// ----------------------------------------------------------------------------
// WebSocket frame unmasker
// Parses frame headers and streams unmasked payload words with frame flags.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker
  import wsfu_pkg::*;
#(
  parameter int unsigned FifoDepthP = FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_of_frame_o,
  output logic       frame_masked_o,
  output logic       first_byte_mismatch_o
);

  logic        accept;
  logic        q_wr, q_rd, q_full, q_empty;
  wsfu_entry_t q_wdata, q_rdata;

  assign full   = q_full;
  assign accept = push && !q_full;

  wsfu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .wr_en_o     (q_wr),
    .wr_data_o   (q_wdata)
  );

  wsfu_queue #(
    .Depth (FifoDepthP)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_wr),
    .wr_data_i (q_wdata),
    .full_o    (q_full),
    .rd_en_i   (q_rd),
    .rd_data_o (q_rdata),
    .empty_o   (q_empty)
  );

  wsfu_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .q_empty_i             (q_empty),
    .q_data_i              (q_rdata),
    .q_rd_o                (q_rd),
    .pop_i                 (pop),
    .empty_o               (empty),
    .out_byte_o            (out_byte_o),
    .last_of_frame_o       (last_of_frame_o),
    .frame_masked_o        (frame_masked_o),
    .first_byte_mismatch_o (first_byte_mismatch_o)
  );

endmodule

[rtl/core/wsfu_front.sv]
// ----------------------------------------------------------------------------
// Frame header parser
// Accepts raw words, walks the frame header and hands each payload word,
// with its key byte and frame flags, to the queue.
// ----------------------------------------------------------------------------
module wsfu_front
  import wsfu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        accept_i,
  input  logic [7:0]  in_byte_i,
  output logic        wr_en_o,
  output wsfu_entry_t wr_data_o
);

  phase_e      phase_q, phase_d;
  logic [63:0] rem_len_q, rem_len_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  key_idx_q, key_idx_d;
  logic        masked_q, masked_d;
  logic        mismatch_q, mismatch_d;
  logic [7:0]  expected_q;

  logic [6:0]  len7;
  logic [63:0] rem_shift;
  logic [63:0] rem_dec;
  logic [7:0]  key_byte;

  assign len7      = in_byte_i[6:0];
  assign rem_shift = {rem_len_q[55:0], in_byte_i};
  assign rem_dec   = rem_len_q - 64'd1;

  always_comb begin
    case (key_idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    rem_len_d  = rem_len_q;
    hdr_cnt_d  = hdr_cnt_q;
    key_d      = key_q;
    key_idx_d  = key_idx_q;
    masked_d   = masked_q;
    mismatch_d = mismatch_q;
    wr_en_o    = 1'b0;
    wr_data_o.data     = in_byte_i;
    wr_data_o.key      = key_byte;
    wr_data_o.last     = (rem_dec == 64'd0);
    wr_data_o.masked   = masked_q;
    wr_data_o.mismatch = mismatch_q;
    if (accept_i) begin
      case (phase_q)
        PhLen: begin
          masked_d  = in_byte_i[7];
          key_d     = 32'd0;
          rem_len_d = 64'd0;
          if (len7 == LenExt16) begin
            hdr_cnt_d = ExtCount16;
            phase_d   = PhExt;
          end else if (len7 == LenExt64) begin
            hdr_cnt_d = ExtCount64;
            phase_d   = PhExt;
          end else begin
            rem_len_d = {57'd0, len7};
            if (in_byte_i[7]) begin
              hdr_cnt_d = KeyCount;
              phase_d   = PhKey;
            end else begin
              key_idx_d = 2'd0;
              phase_d   = (len7 == 7'd0) ? PhFirst : PhPayload;
            end
          end
        end
        PhExt: begin
          rem_len_d = rem_shift;
          if (hdr_cnt_q == 3'd0) begin
            if (masked_q) begin
              hdr_cnt_d = KeyCount;
              phase_d   = PhKey;
            end else begin
              key_idx_d = 2'd0;
              phase_d   = (rem_shift == 64'd0) ? PhFirst : PhPayload;
            end
          end else begin
            hdr_cnt_d = hdr_cnt_q - 3'd1;
          end
        end
        PhKey: begin
          key_d = {key_q[23:0], in_byte_i};
          if (hdr_cnt_q == 3'd0) begin
            key_idx_d = 2'd0;
            phase_d   = (rem_len_q == 64'd0) ? PhFirst : PhPayload;
          end else begin
            hdr_cnt_d = hdr_cnt_q - 3'd1;
          end
        end
        PhPayload: begin
          wr_en_o   = 1'b1;
          rem_len_d = rem_dec;
          key_idx_d = key_idx_q + 2'd1;
          if (rem_dec == 64'd0) begin
            phase_d = PhFirst;
          end
        end
        default: begin
          // The first header word is handled here; unused phase codes are also treated as the start of a frame.
          mismatch_d = (in_byte_i != expected_q);
          phase_d    = PhLen;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhFirst;
      rem_len_q  <= 64'd0;
      hdr_cnt_q  <= 3'd0;
      key_q      <= 32'd0;
      key_idx_q  <= 2'd0;
      masked_q   <= 1'b0;
      mismatch_q <= 1'b0;
      expected_q <= FirstDefault;
    end else begin
      phase_q    <= phase_d;
      rem_len_q  <= rem_len_d;
      hdr_cnt_q  <= hdr_cnt_d;
      key_q      <= key_d;
      key_idx_q  <= key_idx_d;
      masked_q   <= masked_d;
      mismatch_q <= mismatch_d;
      if (cfg_we_i) begin
        expected_q <= cfg_wdata_i;
      end
    end
  end

endmodule

[rtl/core/wsfu_queue.sv]
// ----------------------------------------------------------------------------
// Payload word queue
// Short first-in first-out store between the header parser and the
// unmasking back end.
// ----------------------------------------------------------------------------
module wsfu_queue
  import wsfu_pkg::*;
#(
  parameter int unsigned Depth = FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  wsfu_entry_t wr_data_i,
  output logic        full_o,
  input  logic        rd_en_i,
  output wsfu_entry_t rd_data_o,
  output logic        empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wsfu_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (wr_en_i && !rd_en_i) begin
        count_q <= count_q + CntW'(1);
      end else if (rd_en_i && !wr_en_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/core/wsfu_back.sv]
// ----------------------------------------------------------------------------
// Unmasking back end
// Takes payload words from the queue, applies the key byte and holds the
// result in an output register until it is popped.
// ----------------------------------------------------------------------------
module wsfu_back
  import wsfu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  wsfu_entry_t q_data_i,
  output logic        q_rd_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [7:0]  out_byte_o,
  output logic        last_of_frame_o,
  output logic        frame_masked_o,
  output logic        first_byte_mismatch_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q, masked_q, mismatch_q;

  // The output register refills in the same cycle that it is popped, if the queue is not empty.
  assign q_rd_o  = !q_empty_i && (!valid_q || pop_i);
  assign empty_o = !valid_q;

  assign out_byte_o            = data_q;
  assign last_of_frame_o       = last_q;
  assign frame_masked_o        = masked_q;
  assign first_byte_mismatch_o = mismatch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_rd_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      data_q     <= q_data_i.data ^ q_data_i.key;
      last_q     <= q_data_i.last;
      masked_q   <= q_data_i.masked;
      mismatch_q <= q_data_i.mismatch;
    end
  end

endmodule

[rtl/core/wsfu_checker.sv]
// ----------------------------------------------------------------------------
// WebSocket frame unmasker checker
// Port-level assertions on the unmasker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module wsfu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       last_of_frame_o,
  input logic       frame_masked_o,
  input logic       first_byte_mismatch_o
);

  // Nothing is offered in the cycle after reset has been seen.
  assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result offered during reset");

  // A word that is not popped stays on the result ports unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(last_of_frame_o)
                          && $stable(frame_masked_o) && $stable(first_byte_mismatch_o)))
    else $error("waiting result changed or vanished");

  // An idle output stays idle if no word is accepted now and none was accepted at the last clock edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !(push && !full) && !$past(push && !full)) |=> empty)
    else $error("result appeared without an accepted word");

  // The queue can only fill up behind a result that is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> !empty)
    else $error("input stalled while the output is empty");

endmodule

bind websocket_frame_unmasker wsfu_checker u_wsfu_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .push                  (push),
  .full                  (full),
  .empty                 (empty),
  .pop                   (pop),
  .out_byte_o            (out_byte_o),
  .last_of_frame_o       (last_of_frame_o),
  .frame_masked_o        (frame_masked_o),
  .first_byte_mismatch_o (first_byte_mismatch_o)
);
